[hw/rtl/midpoint_circle_octant_generator_assert.svh]
// Assertion macros used by the checker file of this block.
// Each macro takes a label, the clock, the active-low reset and the expressions.
`ifndef MIDPOINT_CIRCLE_OCTANT_GENERATOR_ASSERT_SVH
`define MIDPOINT_CIRCLE_OCTANT_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCOG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("midpoint circle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MCOG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("midpoint circle assertion failed");

`endif

[hw/rtl/mcog_pkg.sv]
package mcog_pkg;

    localparam int CX_W        = 12;
    localparam int RADIUS_W    = 7;
    localparam int COORD_W     = 14;
    localparam int MAX_RADIUS  = 64;
    localparam int RESULT_CAP  = 48;
    // Offset a holds values up to the maximum radius.
    localparam int A_W         = $clog2(MAX_RADIUS + 1);
    localparam int N_W         = $clog2(RESULT_CAP + 1);
    // The error term stays within a few times the radius in magnitude.
    localparam int ERR_W       = A_W + 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [CX_W-1:0] cx;
        logic [CX_W-1:0] cy;
        logic [A_W-1:0]  r;
    } t_req;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_back_state;

endpackage

[hw/rtl/mcog_front.sv]
module mcog_front (
    input  logic                     i_in_valid,
    input  logic [mcog_pkg::CX_W-1:0]     i_center_x,
    input  logic [mcog_pkg::CX_W-1:0]     i_center_y,
    input  logic [mcog_pkg::RADIUS_W-1:0] i_radius,
    input  logic                     i_queue_full,
    output logic                     o_in_stall,
    output logic                     o_push,
    output mcog_pkg::t_req           o_req
);
    import mcog_pkg::*;

    logic w_clamp;

    // Requests wait at the input while the queue has no free entry.
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    assign w_clamp  = (i_radius > RADIUS_W'(MAX_RADIUS));
    assign o_req.cx = i_center_x;
    assign o_req.cy = i_center_y;
    assign o_req.r  = w_clamp ? A_W'(MAX_RADIUS) : A_W'(i_radius);

endmodule

[hw/rtl/mcog_fifo.sv]
module mcog_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcog_pkg::t_req i_wr_data,
    input  logic           i_pop,
    output mcog_pkg::t_req o_rd_data,
    output logic           o_full,
    output logic           o_empty
);
    import mcog_pkg::*;

    t_req                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count, n_count;

    assign o_full    = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

[hw/rtl/mcog_back.sv]
module mcog_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mcog_pkg::t_req                   i_req,
    input  logic                             i_queue_empty,
    output logic                             o_pop,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic signed [mcog_pkg::COORD_W-1:0] o_x_plus_far,
    output logic signed [mcog_pkg::COORD_W-1:0] o_x_minus_far,
    output logic signed [mcog_pkg::COORD_W-1:0] o_x_plus_near,
    output logic signed [mcog_pkg::COORD_W-1:0] o_x_minus_near,
    output logic signed [mcog_pkg::COORD_W-1:0] o_y_plus_far,
    output logic signed [mcog_pkg::COORD_W-1:0] o_y_minus_far,
    output logic signed [mcog_pkg::COORD_W-1:0] o_y_plus_near,
    output logic signed [mcog_pkg::COORD_W-1:0] o_y_minus_near,
    output logic                             o_last
);
    import mcog_pkg::*;

    t_back_state             r_state, n_state;
    logic [A_W-1:0]          r_a, r_b;
    logic signed [ERR_W-1:0] r_err;
    logic [N_W-1:0]          r_n;
    logic [CX_W-1:0]         r_cx, r_cy;
    logic                    r_out_valid;

    logic                    w_load;
    logic                    w_emit;
    logic [A_W-1:0]          w_b_next;
    logic [A_W-1:0]          w_a_next;
    logic [N_W-1:0]          w_n_next;
    logic signed [ERR_W-1:0] w_bn_s;
    logic signed [ERR_W-1:0] w_a_s;
    logic signed [ERR_W-1:0] w_e1;
    logic signed [ERR_W-1:0] w_diff;
    logic signed [ERR_W-1:0] w_err_next;
    logic                    w_dec;
    logic                    w_fin;
    logic [COORD_W-1:0]      w_cx, w_cy, w_a, w_b;

    // The output register takes a new result whenever it is empty or being drained.
    assign w_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_queue_empty) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_load && w_fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        w_emit = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop  = !i_queue_empty;
            ST_RUN:  w_emit = w_load;
            default: begin
                o_pop  = 1'b0;
                w_emit = 1'b0;
            end
        endcase
    end

    // One step of the recurrence. A decrement of a is taken when err - a is not negative.
    always_comb begin
        w_b_next   = r_b + 1'b1;
        w_n_next   = r_n + 1'b1;
        w_bn_s     = $signed(ERR_W'(w_b_next));
        w_a_s      = $signed(ERR_W'(r_a));
        w_e1       = r_err + w_bn_s + w_bn_s + ERR_W'(1);
        w_diff     = w_e1 - w_a_s;
        w_dec      = !w_diff[ERR_W-1];
        w_a_next   = w_dec ? r_a - 1'b1 : r_a;
        w_err_next = w_dec ? (w_e1 + ERR_W'(3) - w_a_s - w_a_s) : w_e1;
        // Compare before the decrement so that a never has to go below zero.
        w_fin      = (w_dec ? (r_a <= w_b_next) : (r_a < w_b_next))
                     || (w_n_next >= N_W'(RESULT_CAP));
    end

    assign w_cx = COORD_W'(r_cx);
    assign w_cy = COORD_W'(r_cy);
    assign w_a  = COORD_W'(r_a);
    assign w_b  = COORD_W'(r_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cx  <= i_req.cx;
            r_cy  <= i_req.cy;
            r_a   <= i_req.r;
            r_b   <= '0;
            r_err <= '0;
            r_n   <= '0;
        end else if (w_emit) begin
            r_a   <= w_a_next;
            r_b   <= w_b_next;
            r_err <= w_err_next;
            r_n   <= w_n_next;
        end
        if (w_emit) begin
            o_x_plus_far   <= $signed(w_cx + w_a);
            o_x_minus_far  <= $signed(w_cx - w_a);
            o_x_plus_near  <= $signed(w_cx + w_b);
            o_x_minus_near <= $signed(w_cx - w_b);
            o_y_plus_far   <= $signed(w_cy + w_a);
            o_y_minus_far  <= $signed(w_cy - w_a);
            o_y_plus_near  <= $signed(w_cy + w_b);
            o_y_minus_near <= $signed(w_cy - w_b);
            o_last         <= w_fin;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/midpoint_circle_octant_generator.sv]
// Midpoint circle octant generator.
// Input channel (i_in_valid / o_in_stall) carries one circle request: centre
// column, centre row and radius. A radius above 64 is clamped to 64.
// Output channel (o_out_valid / i_out_stall) carries one result per step of
// the recurrence: the four x and four y coordinates of the eight symmetric
// outline points, with o_last set on the final result of the circle.
// A transfer happens on a rising edge with valid high and stall low.
// Requests enter a two-entry queue, so up to two may be taken while a circle
// is still being traced. The tracing unit pulls one request at a time: it
// first loads the request from the queue into its recurrence registers, then
// delivers one result per cycle while the receiver keeps stall low. A circle
// of radius r gives about r / sqrt(2) + 1 results, 46 at the largest radius.
// A request transferred into an idle block is written to the queue, then
// loaded into the recurrence registers; its first result then goes into the result register.
// When the receiver stalls, the result register holds its value and the
// recurrence waits; the queue then fills and o_in_stall rises.
// Reset (synchronous, active low) empties the queue and the result register.
module midpoint_circle_octant_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mcog_pkg::CX_W-1:0]        i_center_x,
    input  logic [mcog_pkg::CX_W-1:0]        i_center_y,
    input  logic [mcog_pkg::RADIUS_W-1:0]    i_radius,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [mcog_pkg::COORD_W-1:0] o_x_plus_far,
    output logic signed [mcog_pkg::COORD_W-1:0] o_x_minus_far,
    output logic signed [mcog_pkg::COORD_W-1:0] o_x_plus_near,
    output logic signed [mcog_pkg::COORD_W-1:0] o_x_minus_near,
    output logic signed [mcog_pkg::COORD_W-1:0] o_y_plus_far,
    output logic signed [mcog_pkg::COORD_W-1:0] o_y_minus_far,
    output logic signed [mcog_pkg::COORD_W-1:0] o_y_plus_near,
    output logic signed [mcog_pkg::COORD_W-1:0] o_y_minus_near,
    output logic                             o_last
);
    import mcog_pkg::*;

    t_req w_push_req;
    t_req w_pop_req;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    mcog_front u_front (
        .i_in_valid   (i_in_valid),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_queue_full (w_full),
        .o_in_stall   (o_in_stall),
        .o_push       (w_push),
        .o_req        (w_push_req)
    );

    mcog_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_push_req),
        .i_pop     (w_pop),
        .o_rd_data (w_pop_req),
        .o_full    (w_full),
        .o_empty   (w_empty)
    );

    mcog_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_pop_req),
        .i_queue_empty  (w_empty),
        .o_pop          (w_pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_x_plus_far   (o_x_plus_far),
        .o_x_minus_far  (o_x_minus_far),
        .o_x_plus_near  (o_x_plus_near),
        .o_x_minus_near (o_x_minus_near),
        .o_y_plus_far   (o_y_plus_far),
        .o_y_minus_far  (o_y_minus_far),
        .o_y_plus_near  (o_y_plus_near),
        .o_y_minus_near (o_y_minus_near),
        .o_last         (o_last)
    );

endmodule

[hw/rtl/mcog_checker.sv]
`include "midpoint_circle_octant_generator_assert.svh"

module mcog_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [mcog_pkg::CX_W-1:0]        i_center_x,
    input logic [mcog_pkg::CX_W-1:0]        i_center_y,
    input logic [mcog_pkg::RADIUS_W-1:0]    i_radius,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic signed [mcog_pkg::COORD_W-1:0] o_x_plus_far,
    input logic signed [mcog_pkg::COORD_W-1:0] o_x_minus_far,
    input logic signed [mcog_pkg::COORD_W-1:0] o_x_plus_near,
    input logic signed [mcog_pkg::COORD_W-1:0] o_x_minus_near,
    input logic signed [mcog_pkg::COORD_W-1:0] o_y_plus_far,
    input logic signed [mcog_pkg::COORD_W-1:0] o_y_minus_far,
    input logic signed [mcog_pkg::COORD_W-1:0] o_y_plus_near,
    input logic signed [mcog_pkg::COORD_W-1:0] o_y_minus_near,
    input logic                             o_last
);
    import mcog_pkg::*;

    // A stalled request stays in place until it is transferred.
    `MCOG_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_center_x) && $stable(i_center_y) && $stable(i_radius))

    // A stalled result stays in place until it is transferred.
    `MCOG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_x_plus_far) && $stable(o_y_minus_near) && $stable(o_last))

    // Both x pairs are centred on the same column, and both y pairs on the same row.
    `MCOG_ASSERT_SAME(a_centre, i_clk, i_rst_n, o_out_valid,
        (COORD_W'(o_x_plus_far + o_x_minus_far) == COORD_W'(o_x_plus_near + o_x_minus_near))
        && (COORD_W'(o_y_plus_far + o_y_minus_far) == COORD_W'(o_y_plus_near + o_y_minus_near)))

    // The gap between far and near offsets is the same along both axes.
    `MCOG_ASSERT_SAME(a_offset_gap, i_clk, i_rst_n, o_out_valid,
        COORD_W'(o_x_plus_far - o_x_plus_near) == COORD_W'(o_y_plus_far - o_y_plus_near))

    // Within a circle, results follow one another without a gap.
    `MCOG_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last,
        o_out_valid)

endmodule

bind midpoint_circle_octant_generator mcog_checker u_mcog_checker (.*);

[dv/circle_outline_checker.sv]
// Watches both channels of the circle generator, predicts the outline steps of every accepted
// request and compares each accepted result against the oldest outstanding step.
module circle_outline_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [mcog_pkg::CX_W-1:0]           i_center_x,
    input  logic [mcog_pkg::CX_W-1:0]           i_center_y,
    input  logic [mcog_pkg::RADIUS_W-1:0]       i_radius,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [mcog_pkg::COORD_W-1:0] i_x_plus_far,
    input  logic signed [mcog_pkg::COORD_W-1:0] i_x_minus_far,
    input  logic signed [mcog_pkg::COORD_W-1:0] i_x_plus_near,
    input  logic signed [mcog_pkg::COORD_W-1:0] i_x_minus_near,
    input  logic signed [mcog_pkg::COORD_W-1:0] i_y_plus_far,
    input  logic signed [mcog_pkg::COORD_W-1:0] i_y_minus_far,
    input  logic signed [mcog_pkg::COORD_W-1:0] i_y_plus_near,
    input  logic signed [mcog_pkg::COORD_W-1:0] i_y_minus_near,
    input  logic                                i_last,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = mcog_pkg::COORD_W;

    typedef struct packed {
        logic signed [CW-1:0] x_plus_far;
        logic signed [CW-1:0] x_minus_far;
        logic signed [CW-1:0] x_plus_near;
        logic signed [CW-1:0] x_minus_near;
        logic signed [CW-1:0] y_plus_far;
        logic signed [CW-1:0] y_minus_far;
        logic signed [CW-1:0] y_plus_near;
        logic signed [CW-1:0] y_minus_near;
        logic                 last;
    } t_outline_step;

    t_outline_step steps_due[$];
    t_outline_step want;
    int            fails = 0;

    // Runs the midpoint recurrence for one request and queues every step it yields.
    function automatic void trace_outline(input logic [mcog_pkg::CX_W-1:0] cx_in,
                                          input logic [mcog_pkg::CX_W-1:0] cy_in,
                                          input logic [mcog_pkg::RADIUS_W-1:0] radius_in);
        int            cx;
        int            cy;
        int            a;
        int            b;
        int            err;
        int            n;
        t_outline_step s;
        cx = int'(cx_in);
        cy = int'(cy_in);
        a = int'(radius_in);
        if (a > mcog_pkg::MAX_RADIUS) begin
            a = mcog_pkg::MAX_RADIUS;
        end
        b = 0;
        err = 0;
        n = 0;
        while (a >= b && n < mcog_pkg::RESULT_CAP) begin
            s.x_plus_far   = CW'(cx + a);
            s.x_minus_far  = CW'(cx - a);
            s.x_plus_near  = CW'(cx + b);
            s.x_minus_near = CW'(cx - b);
            s.y_plus_far   = CW'(cy + a);
            s.y_minus_far  = CW'(cy - a);
            s.y_plus_near  = CW'(cy + b);
            s.y_minus_near = CW'(cy - b);
            b = b + 1;
            err = err + 1 + 2 * b;
            if (2 * (err - a) + 1 > 0) begin
                a = a - 1;
                err = err + 1 - 2 * a;
            end
            n = n + 1;
            s.last = (a < b) || (n >= mcog_pkg::RESULT_CAP);
            steps_due.push_back(s);
        end
    endfunction

    function automatic void check_field(input string name, input logic signed [CW-1:0] exp_v,
                                        input logic signed [CW-1:0] got_v);
        if (exp_v !== got_v) begin
            fails = fails + 1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name,
                     exp_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                trace_outline(i_center_x, i_center_y, i_radius);
            end
            if (i_out_valid && !i_out_stall) begin
                if (steps_due.size() == 0) begin
                    fails = fails + 1;
                    $display("%0t: unexpected result, expected none, actual x %0d y %0d",
                             $realtime, i_x_plus_far, i_y_plus_far);
                end else begin
                    want = steps_due.pop_front();
                    check_field("x_plus_far", want.x_plus_far, i_x_plus_far);
                    check_field("x_minus_far", want.x_minus_far, i_x_minus_far);
                    check_field("x_plus_near", want.x_plus_near, i_x_plus_near);
                    check_field("x_minus_near", want.x_minus_near, i_x_minus_near);
                    check_field("y_plus_far", want.y_plus_far, i_y_plus_far);
                    check_field("y_minus_far", want.y_minus_far, i_y_minus_far);
                    check_field("y_plus_near", want.y_plus_near, i_y_plus_near);
                    check_field("y_minus_near", want.y_minus_near, i_y_minus_near);
                    check_field("last", CW'(want.last), CW'(i_last));
                end
            end
        end
        o_pending <= steps_due.size();
        o_fail_count <= fails;
    end

endmodule

[dv/midpoint_circle_octant_generator_tb.sv]
module midpoint_circle_octant_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = mcog_pkg::COORD_W;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 60;
    localparam int ITEMS_PER_PHASE = 160;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic [mcog_pkg::CX_W-1:0]           i_center_x;
    logic [mcog_pkg::CX_W-1:0]           i_center_y;
    logic [mcog_pkg::RADIUS_W-1:0]       i_radius;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic signed [CW-1:0]                o_x_plus_far;
    logic signed [CW-1:0]                o_x_minus_far;
    logic signed [CW-1:0]                o_x_plus_near;
    logic signed [CW-1:0]                o_x_minus_near;
    logic signed [CW-1:0]                o_y_plus_far;
    logic signed [CW-1:0]                o_y_minus_far;
    logic signed [CW-1:0]                o_y_plus_near;
    logic signed [CW-1:0]                o_y_minus_near;
    logic                                o_last;

    int steps_pending;
    int fail_count;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;

    midpoint_circle_octant_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_x_plus_far   (o_x_plus_far),
        .o_x_minus_far  (o_x_minus_far),
        .o_x_plus_near  (o_x_plus_near),
        .o_x_minus_near (o_x_minus_near),
        .o_y_plus_far   (o_y_plus_far),
        .o_y_minus_far  (o_y_minus_far),
        .o_y_plus_near  (o_y_plus_near),
        .o_y_minus_near (o_y_minus_near),
        .o_last         (o_last)
    );

    circle_outline_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_x_plus_far   (o_x_plus_far),
        .i_x_minus_far  (o_x_minus_far),
        .i_x_plus_near  (o_x_plus_near),
        .i_x_minus_near (o_x_minus_near),
        .i_y_plus_far   (o_y_plus_far),
        .i_y_minus_far  (o_y_minus_far),
        .i_y_plus_near  (o_y_plus_near),
        .i_y_minus_near (o_y_minus_near),
        .i_last         (o_last),
        .o_pending      (steps_pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[midpoint_circle_octant_generator] ERROR");
            $finish;
        end
    end

    // Returns at the edge where the request is transferred; valid is left high so that a
    // following request can go out back to back.
    task automatic send_circle(input logic [mcog_pkg::CX_W-1:0] cx,
                               input logic [mcog_pkg::CX_W-1:0] cy,
                               input logic [mcog_pkg::RADIUS_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius <= r;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every queued outline step has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (steps_pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [mcog_pkg::CX_W-1:0] pick_coord();
        int k;
        k = $urandom_range(99);
        if (k < 5) begin
            return '0;
        end else if (k < 10) begin
            return '1;
        end
        return mcog_pkg::CX_W'($urandom_range(4095));
    endfunction

    // Mostly legal radii, with a share of tiny circles and of radii that get clamped.
    function automatic logic [mcog_pkg::RADIUS_W-1:0] pick_radius();
        int k;
        k = $urandom_range(99);
        if (k < 15) begin
            return mcog_pkg::RADIUS_W'($urandom_range(3));
        end else if (k < 30) begin
            return mcog_pkg::RADIUS_W'($urandom_range(127, 65));
        end
        return mcog_pkg::RADIUS_W'($urandom_range(64));
    endfunction

    task automatic send_random_phase(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_stall_pct <= receiver_pct;
        repeat (ITEMS_PER_PHASE) begin
            send_circle(pick_coord(), pick_coord(), pick_radius());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_center_x = '0;
        i_center_y = '0;
        i_radius = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 14;
        recv_stall_pct <= 87;

        // Zero radius gives a single step sitting on the centre.
        send_circle(12'd0, 12'd0, 7'd0);
        send_circle(12'd4095, 12'd4095, 7'd0);
        send_circle(12'd2048, 12'd2048, 7'd1);
        send_circle(12'd2048, 12'd2048, 7'd2);
        send_circle(12'd100, 12'd200, 7'd3);
        send_circle(12'd5, 12'd7, 7'd5);
        // Full radius at both corners drives coordinates below zero and past the top.
        send_circle(12'd0, 12'd0, 7'd64);
        send_circle(12'd4095, 12'd4095, 7'd64);
        send_circle(12'd0, 12'd0, 7'd63);
        send_circle(12'd64, 12'd64, 7'd64);
        // Radii above the maximum are clamped.
        send_circle(12'd0, 12'd4095, 7'd65);
        send_circle(12'd4095, 12'd0, 7'd127);
        send_circle(12'd1000, 12'd3000, 7'd100);
        send_circle(12'd2730, 12'd1365, 7'd42);
        send_circle(12'd1365, 12'd2730, 7'd85);
        send_circle(12'd4031, 12'd63, 7'd8);

        send_random_phase(14, 87);
        drain_results();
        send_random_phase(87, 14);
        drain_results();
        send_random_phase(0, 0);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[midpoint_circle_octant_generator] OK");
        end else begin
            $display("[midpoint_circle_octant_generator] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mcog_pkg.sv
hw/rtl/mcog_front.sv
hw/rtl/mcog_fifo.sv
hw/rtl/mcog_back.sv
hw/rtl/midpoint_circle_octant_generator.sv
hw/rtl/mcog_checker.sv
dv/circle_outline_checker.sv
dv/midpoint_circle_octant_generator_tb.sv
